// File: rtl/spwt_pkg.sv
package spwt_pkg;

    // Timer width default and fixed field widths
    localparam int TIME_BITS_DEF = 48;
    localparam int TS_W          = 48;
    localparam int CONN_W        = 16;
    localparam int LIMIT_W       = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    // Request codes
    localparam logic [3:0] REQ_ARM        = 4'd0;
    localparam logic [3:0] REQ_DISARM     = 4'd1;
    localparam logic [3:0] REQ_CONNECT    = 4'd2;
    localparam logic [3:0] REQ_DISCONNECT = 4'd3;
    localparam logic [3:0] REQ_ACTIVITY   = 4'd4;
    localparam logic [3:0] REQ_POLL       = 4'd5;
    localparam logic [3:0] REQ_IDLE_DROP  = 4'd6;
    localparam logic [3:0] REQ_TO_WIPE    = 4'd7;
    localparam logic [3:0] REQ_RECLAIM    = 4'd8;
    localparam logic [3:0] REQ_BOOT_ARM   = 4'd9;

    // Poll verdicts
    localparam logic [1:0] VERDICT_NONE = 2'd0;
    localparam logic [1:0] VERDICT_WIPE = 2'd1;
    localparam logic [1:0] VERDICT_DROP = 2'd2;

    // Notification actions
    localparam logic [1:0] ACT_IDLE_DROP = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT   = 2'd1;
    localparam logic [1:0] ACT_RECLAIM   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP_DONE = 2'd3;

    // Configuration reset values
    localparam logic [LIMIT_W-1:0] ARM_WINDOW_RST = 32'd300000000;
    localparam logic [LIMIT_W-1:0] DEADLINE_RST   = 32'd600000000;
    localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST = 32'd60000000;

    // One result item
    typedef struct packed {
        logic [1:0]        poll_verdict;
        logic              is_armed;
        logic              owns_buttons;
        logic              notify_valid;
        logic [1:0]        notify_action;
        logic [CONN_W-1:0] notify_conn;
    } t_result;

endpackage

// File: rtl/spwt_ifs.sv
// Request channel
interface spwt_in_if;
    logic                       valid;
    logic                       ready;
    logic [3:0]                 req_type;
    logic [spwt_pkg::TS_W-1:0]  timestamp;
    logic [spwt_pkg::CONN_W-1:0] conn_id;

    modport source (output valid, req_type, timestamp, conn_id, input ready);
    modport sink   (input valid, req_type, timestamp, conn_id, output ready);
endinterface

// Result channel
interface spwt_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  poll_verdict;
    logic                        is_armed;
    logic                        owns_buttons;
    logic                        notify_valid;
    logic [1:0]                  notify_action;
    logic [spwt_pkg::CONN_W-1:0] notify_conn;

    modport source (output valid, poll_verdict, is_armed, owns_buttons, notify_valid,
                    notify_action, notify_conn, input ready);
    modport sink   (input valid, poll_verdict, is_armed, owns_buttons, notify_valid,
                    notify_action, notify_conn, output ready);
endinterface

// File: rtl/spwt_expiry.sv
module spwt_expiry #(
    parameter int TIME_BITS = spwt_pkg::TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0]             i_now,
    input  logic [TIME_BITS-1:0]             i_start,
    input  logic [spwt_pkg::LIMIT_W-1:0]     i_limit,
    output logic                             o_expired
);
    import spwt_pkg::*;

    logic [TIME_BITS-1:0] elapsed;

    // Elapsed time wraps modulo 2^TIME_BITS
    assign elapsed   = i_now - i_start;
    assign o_expired = (elapsed >= TIME_BITS'(i_limit));

endmodule

// File: rtl/setup_phase_window_timer.sv
// Setup-window supervisor. Each request item (arm, disarm, connect, disconnect,
// activity, poll, idle drop, timeout wipe, reclaim, boot arm) is accepted and its
// result item registered in the output buffer; a new request can be taken every
// cycle while a buffer entry is free. The state update, the three wrap-around
// elapsed-time compares and the poll priority select are done combinationally
// before the result register. Results go into a two-entry output buffer, so
// requests keep flowing while one result waits; requests stall only when both
// entries are held. The user must write configuration through the plain write
// port only while no request is in flight; the block does not enforce this.
module setup_phase_window_timer #(
    parameter int TIME_BITS = spwt_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    spwt_in_if.sink                           i_req,
    spwt_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [spwt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spwt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import spwt_pkg::*;

    // Configuration
    logic [LIMIT_W-1:0] r_arm_window, r_deadline, r_idle_limit;
    logic               r_setup_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_window <= ARM_WINDOW_RST;
            r_deadline   <= DEADLINE_RST;
            r_idle_limit <= IDLE_LIMIT_RST;
            r_setup_done <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ARM_WINDOW: r_arm_window <= i_cfg_data;
                CFG_DEADLINE:   r_deadline   <= i_cfg_data;
                CFG_IDLE_LIMIT: r_idle_limit <= i_cfg_data;
                CFG_SETUP_DONE: r_setup_done <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Supervisor state
    logic                 r_armed, n_armed;
    logic                 r_dl_run, n_dl_run;
    logic                 r_conn, n_conn;
    logic [TIME_BITS-1:0] r_armed_time, n_armed_time;
    logic [TIME_BITS-1:0] r_dl_time, n_dl_time;
    logic [TIME_BITS-1:0] r_act_time, n_act_time;
    logic [CONN_W-1:0]    r_held_conn, n_held_conn;

    logic                 accept;
    logic [TIME_BITS-1:0] now;
    logic                 dl_exp, idle_exp, win_exp;
    t_result              res;

    assign accept = i_req.valid && i_req.ready;
    assign now    = TIME_BITS'(i_req.timestamp);

    spwt_expiry #(.TIME_BITS(TIME_BITS)) u_dl_exp (
        .i_now(now), .i_start(r_dl_time), .i_limit(r_deadline), .o_expired(dl_exp)
    );
    spwt_expiry #(.TIME_BITS(TIME_BITS)) u_idle_exp (
        .i_now(now), .i_start(r_act_time), .i_limit(r_idle_limit), .o_expired(idle_exp)
    );
    spwt_expiry #(.TIME_BITS(TIME_BITS)) u_win_exp (
        .i_now(now), .i_start(r_armed_time), .i_limit(r_arm_window), .o_expired(win_exp)
    );

    // Request decode and next state
    always_comb begin
        n_armed      = r_armed;
        n_dl_run     = r_dl_run;
        n_conn       = r_conn;
        n_armed_time = r_armed_time;
        n_dl_time    = r_dl_time;
        n_act_time   = r_act_time;
        n_held_conn  = r_held_conn;
        res          = '0;
        unique case (i_req.req_type) inside
            REQ_ARM, REQ_RECLAIM: begin
                n_armed      = 1'b1;
                n_armed_time = now;
                if (r_dl_run) n_dl_time = now;
                if (i_req.req_type == REQ_RECLAIM) begin
                    res.notify_valid  = 1'b1;
                    res.notify_action = ACT_RECLAIM;
                    res.notify_conn   = r_held_conn;
                end
            end
            REQ_BOOT_ARM: begin
                if (!r_setup_done) begin
                    n_armed      = 1'b1;
                    n_armed_time = now;
                    if (r_dl_run) n_dl_time = now;
                end
            end
            REQ_DISARM: begin
                n_armed = 1'b0;
                n_conn  = 1'b0;
            end
            REQ_CONNECT: begin
                if (!r_conn) begin
                    n_conn      = 1'b1;
                    n_held_conn = i_req.conn_id;
                    n_act_time  = now;
                    if (!r_dl_run) begin
                        n_dl_run  = 1'b1;
                        n_dl_time = now;
                    end
                end
            end
            REQ_DISCONNECT: n_conn = 1'b0;
            REQ_ACTIVITY: begin
                if (r_conn) n_act_time = now;
            end
            REQ_POLL: begin
                if (r_armed) begin
                    if (r_dl_run && dl_exp)       res.poll_verdict = VERDICT_WIPE;
                    else if (r_conn && idle_exp)  res.poll_verdict = VERDICT_DROP;
                    else if (!r_dl_run && win_exp) res.poll_verdict = VERDICT_WIPE;
                    else                          res.poll_verdict = VERDICT_NONE;
                end
            end
            REQ_IDLE_DROP: begin
                n_conn            = 1'b0;
                res.notify_valid  = 1'b1;
                res.notify_action = ACT_IDLE_DROP;
                res.notify_conn   = r_held_conn;
            end
            REQ_TO_WIPE: begin
                n_armed           = 1'b0;
                n_conn            = 1'b0;
                res.notify_valid  = 1'b1;
                res.notify_action = ACT_TIMEOUT;
            end
            default: ;
        endcase
        res.is_armed     = n_armed;
        res.owns_buttons = n_armed || !r_setup_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_dl_run     <= 1'b0;
            r_conn       <= 1'b0;
            r_armed_time <= '0;
            r_dl_time    <= '0;
            r_act_time   <= '0;
            r_held_conn  <= '0;
        end else if (accept) begin
            r_armed      <= n_armed;
            r_dl_run     <= n_dl_run;
            r_conn       <= n_conn;
            r_armed_time <= n_armed_time;
            r_dl_time    <= n_dl_time;
            r_act_time   <= n_act_time;
            r_held_conn  <= n_held_conn;
        end
    end

    // Two-entry result buffer: head drives the port, second entry catches stalls
    t_result    r_q0, r_q1;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop         = o_res.valid && o_res.ready;
    assign i_req.ready = (r_cnt != 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            unique case (r_cnt)
                2'd0: if (accept) r_cnt <= 2'd1;
                2'd1: if (accept && !pop) r_cnt <= 2'd2;
                      else if (pop && !accept) r_cnt <= 2'd0;
                2'd2: if (pop) r_cnt <= 2'd1;
                default: r_cnt <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_cnt == 2'd0 && accept) || (r_cnt == 2'd1 && accept && pop)) begin
            r_q0 <= res;
        end else if (r_cnt == 2'd2 && pop) begin
            r_q0 <= r_q1;
        end
        if (r_cnt == 2'd1 && accept && !pop) begin
            r_q1 <= res;
        end
    end

    assign o_res.valid         = (r_cnt != 2'd0);
    assign o_res.poll_verdict  = r_q0.poll_verdict;
    assign o_res.is_armed      = r_q0.is_armed;
    assign o_res.owns_buttons  = r_q0.owns_buttons;
    assign o_res.notify_valid  = r_q0.notify_valid;
    assign o_res.notify_action = r_q0.notify_action;
    assign o_res.notify_conn   = r_q0.notify_conn;

endmodule

// File: rtl/spwt_checker.sv
module spwt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [1:0]                  i_poll_verdict,
    input logic                        i_is_armed,
    input logic                        i_owns_buttons,
    input logic                        i_notify_valid,
    input logic [1:0]                  i_notify_action,
    input logic [spwt_pkg::CONN_W-1:0] i_notify_conn
);
    import spwt_pkg::*;

    // Buffer is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // No notification means zeroed action and handle
    a_quiet_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_notify_valid) |->
            (i_notify_action == ACT_IDLE_DROP && i_notify_conn == '0))
        else $error("stray notification payload");

    // Timeout disarms and carries no handle
    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_notify_valid && i_notify_action == ACT_TIMEOUT) |->
            (!i_is_armed && i_notify_conn == '0))
        else $error("timeout result inconsistent");

    // A poll verdict comes only while armed and never with a notification
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_poll_verdict != VERDICT_NONE) |->
            (i_is_armed && i_owns_buttons && !i_notify_valid))
        else $error("verdict on a non-poll or disarmed result");

    // An accepted item produces a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted item left no result");

endmodule

bind setup_phase_window_timer spwt_checker u_spwt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_poll_verdict (o_res.poll_verdict),
    .i_is_armed     (o_res.is_armed),
    .i_owns_buttons (o_res.owns_buttons),
    .i_notify_valid (o_res.notify_valid),
    .i_notify_action(o_res.notify_action),
    .i_notify_conn  (o_res.notify_conn)
);
